[hdl/ava_pkg.sv]
// Shared constants, register indexes, result type and saturation helper of the visual adaptation block.
package ava_pkg;

  localparam int FRAC_BITS = 15;

  localparam logic [15:0] ONE      = 16'd32768;
  localparam logic [15:0] K_0_01   = 16'd328;
  localparam logic [15:0] K_0_02   = 16'd655;
  localparam logic [15:0] K_0_05   = 16'd1638;
  localparam logic [15:0] K_0_2    = 16'd6554;
  localparam logic [15:0] K_0_3    = 16'd9830;
  localparam logic [15:0] K_0_4    = 16'd13107;
  localparam logic [15:0] K_0_5    = 16'd16384;
  localparam logic [15:0] K_0_6    = 16'd19661;
  localparam logic [15:0] K_0_7    = 16'd22938;
  localparam logic [15:0] K_0_8    = 16'd26214;
  localparam logic [17:0] K_2_0    = 18'd65536;
  localparam logic [17:0] K_5_0    = 18'd163840;
  localparam logic [15:0] PERS_MIN  = 16'd5120;
  localparam logic [15:0] PERS_SPAN = 16'd15360;
  localparam logic [15:0] PERS_MAX  = 16'd32767;

  localparam logic [15:0] RECOVERY_RESET  = 16'd328;
  localparam logic [14:0] THRESHOLD_RESET = 15'd16384;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 8'd1;

  typedef struct packed {
    logic [15:0] dark_level;
    logic [15:0] luma_gain;
    logic [15:0] contrast_scale;
    logic [14:0] persistence_time;
    logic [14:0] bloom_level;
    logic [15:0] glare_level;
    logic [15:0] display_brightness;
    logic [15:0] brightness_gap;
    logic [15:0] focus_level;
    logic        raining;
    logic        effect_active;
  } ava_res_t;

  // Saturate a signed sum into [lo, hi].
  function automatic logic [15:0] sat16(input logic signed [23:0] v,
                                        input logic [15:0] lo, input logic [15:0] hi);
    logic [15:0] r;
    if (v < $signed({8'd0, lo})) r = lo;
    else if (v > $signed({8'd0, hi})) r = hi;
    else r = v[15:0];
    return r;
  endfunction

endpackage

[hdl/ava_if.sv]
// Handshake channels of the visual adaptation block: input, result and configuration.
interface ava_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] tick_time;
  logic [15:0] ambient_level;
  logic [15:0] rain_level;
  logic        bright_light;
  modport source (output valid, tick_time, ambient_level, rain_level, bright_light,
                  input ready);
  modport sink (input valid, tick_time, ambient_level, rain_level, bright_light,
                output ready);
endinterface

interface ava_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] dark_level;
  logic [15:0] luma_gain;
  logic [15:0] contrast_scale;
  logic [14:0] persistence_time;
  logic [14:0] bloom_level;
  logic [15:0] glare_level;
  logic [15:0] display_brightness;
  logic [15:0] brightness_gap;
  logic [15:0] focus_level;
  logic        raining;
  logic        effect_active;
  modport source (output valid, dark_level, luma_gain, contrast_scale, persistence_time,
                  bloom_level, glare_level, display_brightness, brightness_gap, focus_level,
                  raining, effect_active, input ready);
  modport sink (input valid, dark_level, luma_gain, contrast_scale, persistence_time,
                bloom_level, glare_level, display_brightness, brightness_gap, focus_level,
                raining, effect_active, output ready);
endinterface

interface ava_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/ava_smul.sv]
// Bit-serial rounding multiplier: round(a*b / 2^sh), halves away from zero.
module ava_smul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [18:0] a_i,
  input  logic [17:0]        b_i,
  input  logic               sh16_i,
  output logic               done_o,
  output logic signed [22:0] res_o
);
  logic        busy_q, busy_d;
  logic [36:0] acc_q, acc_d;
  logic [36:0] a_q, a_d;
  logic [17:0] b_q, b_d;
  logic        neg_q, neg_d;
  logic        sh16_q, sh16_d;
  logic [18:0] mag;
  logic [21:0] shifted;

  assign mag = a_i[18] ? 19'(-a_i) : 19'(a_i);

  always_comb begin
    busy_d = busy_q;
    acc_d  = acc_q;
    a_d    = a_q;
    b_d    = b_q;
    neg_d  = neg_q;
    sh16_d = sh16_q;
    if (start_i) begin
      busy_d = 1'b1;
      a_d    = {18'd0, mag};
      b_d    = b_i;
      neg_d  = a_i[18];
      sh16_d = sh16_i;
      // preload the rounding half
      acc_d  = sh16_i ? 37'd32768 : 37'd16384;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d = 1'b0;
      end else begin
        if (b_q[0]) acc_d = acc_q + a_q;
        a_d = {a_q[35:0], 1'b0};
        b_d = {1'b0, b_q[17:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    a_q    <= a_d;
    b_q    <= b_d;
    neg_q  <= neg_d;
    sh16_q <= sh16_d;
  end

  assign done_o  = busy_q && (b_q == '0);
  assign shifted = sh16_q ? {1'b0, acc_q[36:16]} : acc_q[36:15];
  assign res_o   = neg_q ? -$signed({1'b0, shifted}) : $signed({1'b0, shifted});
endmodule

[hdl/ava_sdiv.sv]
// Restoring divider, one quotient bit per cycle: round((num << 15) / den), num < den.
module ava_sdiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] num_i,
  input  logic [16:0] den_i,
  output logic        done_o,
  output logic [14:0] quo_o
);
  logic        busy_q, done_q;
  logic [3:0]  cnt_q;
  logic [16:0] rem_q;
  logic [16:0] den_q;
  logic [14:0] low_q;
  logic [14:0] quo_q;
  logic [17:0] trial;
  logic        fits;

  // shift in the bits of den/2, the rounding term under the dividend
  assign trial = {rem_q, low_q[14]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd14;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      low_q <= den_i[15:1];
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? 17'(trial - {1'b0, den_q}) : trial[16:0];
      low_q <= {low_q[13:0], 1'b0};
      quo_q <= {quo_q[13:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

[hdl/ambient_visual_adaptation.sv]
// Top level of the ambient visual adaptation block: sequencer, state and result register.
//
// Channels: in_i takes one tick (tick_time, ambient_level, rain_level, bright_light);
// out_o returns one result item per tick; cfg_i writes fatigue_recovery (index 0)
// and the fatigue onset level (index 1), other indexes are dropped. cfg_i is always
// ready and must only be written while the block is idle.
// Sequence: twenty-one products run one after another through one bit-serial
// multiplier that retires one multiplier bit per cycle, and the contrast reduction
// adds a restoring division of 15 quotient bits when fatigue is above the onset
// level but below full scale.
// Throughput: one tick at a time; in_i.ready is high only while the sequencer idles.
// A finished result waits in the output register, so the next tick may be taken
// while the receiver stalls; a second result waits until the first is taken.
// Reset: all tracking states return to their rest values (persistence 20 ms,
// brightness 0.05) and both configuration registers to their defaults.
module ambient_visual_adaptation (
  input  logic clk_i,
  input  logic rst_ni,
  ava_in_if.sink    in_i,
  ava_out_if.source out_o,
  ava_cfg_if.sink   cfg_i
);
  import ava_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DIVW  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [4:0] PC_D1 = 5'd0;
  localparam logic [4:0] PC_D2 = 5'd1;
  localparam logic [4:0] PC_B1 = 5'd2;
  localparam logic [4:0] PC_B2 = 5'd3;
  localparam logic [4:0] PC_BA = 5'd4;
  localparam logic [4:0] PC_N1 = 5'd5;
  localparam logic [4:0] PC_G1 = 5'd6;
  localparam logic [4:0] PC_G2 = 5'd7;
  localparam logic [4:0] PC_P0 = 5'd8;
  localparam logic [4:0] PC_P1 = 5'd9;
  localparam logic [4:0] PC_P2 = 5'd10;
  localparam logic [4:0] PC_P3 = 5'd11;
  localparam logic [4:0] PC_R0 = 5'd12;
  localparam logic [4:0] PC_R1 = 5'd13;
  localparam logic [4:0] PC_R2 = 5'd14;
  localparam logic [4:0] PC_R3 = 5'd15;
  localparam logic [4:0] PC_F1 = 5'd16;
  localparam logic [4:0] PC_F2 = 5'd17;
  localparam logic [4:0] PC_A1 = 5'd18;
  localparam logic [4:0] PC_A2 = 5'd19;
  localparam logic [4:0] PC_L1 = 5'd20;

  logic [2:0]  state_q;
  logic [4:0]  pc_q;
  logic [15:0] rec_q;
  logic [14:0] thr_q;
  logic [15:0] dt_q, amb_q, rain_q;
  logic        bright_q;
  logic [15:0] dark_q, exp_q, bst_q, fat_q, foc_q;
  logic [14:0] pers_q;
  logic signed [18:0] t_q;
  logic [15:0] night_q, glare_q, bt_q, lum_q;
  logic [14:0] bamt_q, cred_q;
  ava_res_t    res_q;
  logic        ovalid_q;

  logic               mul_start, mul_done, mul_sh16;
  logic signed [18:0] mul_a;
  logic [17:0]        mul_b;
  logic signed [22:0] mul_r;
  logic signed [23:0] r24;
  logic               div_start, div_done;
  logic [14:0]        div_quo;
  logic [15:0]        dtarget, atarget, fdiff, gap;
  logic [16:0]        fden;
  logic               amb_hi, fat_over, load_out, active;
  ava_res_t           res_d;

  function automatic logic signed [18:0] d19(input logic [15:0] x, input logic [15:0] y);
    return $signed({3'd0, x}) - $signed({3'd0, y});
  endfunction

  function automatic logic signed [18:0] u19(input logic [15:0] x);
    return $signed({3'd0, x});
  endfunction

  assign dtarget = ONE - amb_q;
  assign amb_hi  = amb_q > K_0_3;
  assign r24     = {mul_r[22], mul_r};

  always_comb begin
    atarget = K_0_3;
    if (amb_q < K_0_2) atarget = K_0_7;
    if (rain_q > K_0_3) atarget = K_0_6;
  end

  // operand select for each step of the program
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    mul_sh16 = 1'b0;
    case (pc_q)
      PC_D1: begin
        mul_a = d19(dtarget, dark_q);
        mul_b = {2'd0, (dtarget > dark_q) ? K_0_8 : K_0_3};
      end
      PC_B1: begin
        mul_a = bright_q ? d19(ONE, exp_q) : 19'sd0;
        mul_b = K_5_0;
      end
      PC_B2: begin
        mul_a    = bright_q ? t_q : $signed({1'b0, K_2_0});
        mul_b    = {2'd0, dt_q};
        mul_sh16 = 1'b1;
      end
      PC_BA: begin mul_a = u19(exp_q);  mul_b = {2'd0, K_0_6}; end
      PC_N1: begin mul_a = u19(dark_q); mul_b = {2'd0, K_0_5}; end
      PC_G1: begin mul_a = u19(rain_q); mul_b = {2'd0, K_0_3}; end
      PC_G2: begin mul_a = t_q;         mul_b = {2'd0, night_q}; end
      PC_P0: begin mul_a = u19(dark_q); mul_b = {2'd0, K_0_6}; end
      PC_P1: begin mul_a = u19(PERS_SPAN); mul_b = t_q[17:0]; end
      PC_P2: begin
        mul_a = t_q - $signed({4'd0, pers_q});
        mul_b = {2'd0, K_0_8};
      end
      PC_R0: begin mul_a = u19(amb_q); mul_b = {2'd0, K_0_7}; end
      PC_R1: begin mul_a = u19(K_0_4); mul_b = {2'd0, night_q}; end
      PC_R2: begin mul_a = d19(bt_q, bst_q); mul_b = t_q[17:0]; end
      PC_F1: begin
        mul_a = amb_hi ? u19(K_0_02) : u19(rec_q);
        mul_b = {2'd0, amb_hi ? amb_q : dtarget};
      end
      PC_A1: begin mul_a = d19(atarget, foc_q); mul_b = {2'd0, K_0_5}; end
      PC_L1: begin mul_a = u19(dark_q); mul_b = {2'd0, K_0_3}; end
      PC_D2, PC_P3, PC_R3, PC_F2, PC_A2: begin
        mul_a    = t_q;
        mul_b    = {2'd0, dt_q};
        mul_sh16 = 1'b1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  ava_smul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh16_i  (mul_sh16),
    .done_o  (mul_done),
    .res_o   (mul_r)
  );

  assign fat_over = fat_q > {1'b0, thr_q};
  assign fdiff    = fat_q - {1'b0, thr_q};
  assign fden     = {1'b0, ONE} - {2'd0, thr_q};

  ava_sdiv u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (fdiff),
    .den_i   (fden),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign mul_start = (state_q == S_ISSUE);
  assign div_start = (state_q == S_DIV);
  assign in_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign load_out = (state_q == S_FIN) && (!ovalid_q || out_o.ready);

  assign gap    = (bt_q > bst_q) ? bt_q - bst_q : bst_q - bt_q;
  assign active = (dark_q > K_0_05) || (bamt_q > K_0_01[14:0]) || (glare_q > K_0_01) ||
                  (cred_q > K_0_01[14:0]) || (gap > K_0_05);

  always_comb begin
    res_d.dark_level         = dark_q;
    res_d.luma_gain          = lum_q;
    res_d.contrast_scale     = ONE - {1'b0, cred_q};
    res_d.persistence_time   = pers_q;
    res_d.bloom_level        = bamt_q;
    res_d.glare_level        = glare_q;
    res_d.display_brightness = bst_q;
    res_d.brightness_gap     = gap;
    res_d.focus_level        = foc_q;
    res_d.raining            = rain_q > K_0_05;
    res_d.effect_active      = active;
  end

  // sequencer, configuration, tracking states and output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pc_q     <= PC_D1;
      ovalid_q <= 1'b0;
      rec_q    <= RECOVERY_RESET;
      thr_q    <= THRESHOLD_RESET;
      dark_q   <= '0;
      exp_q    <= '0;
      pers_q   <= PERS_MIN[14:0];
      bst_q    <= K_0_05;
      fat_q    <= '0;
      foc_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == REG_RECOVERY) rec_q <= cfg_i.data;
        else if (cfg_i.index == REG_THRESHOLD) thr_q <= cfg_i.data[14:0];
      end
      if (load_out) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            pc_q    <= PC_D1;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (mul_done) begin
            case (pc_q)
              PC_D2: dark_q <= sat16({8'd0, dark_q} + r24, '0, ONE);
              PC_B2: begin
                if (bright_q) exp_q <= sat16({8'd0, exp_q} + r24, '0, ONE);
                else if (exp_q > K_0_01) exp_q <= sat16({8'd0, exp_q} - r24, '0, ONE);
              end
              PC_P3: pers_q <= 15'(sat16({9'd0, pers_q} + r24, '0, PERS_MAX));
              PC_R3: bst_q  <= sat16({8'd0, bst_q} + r24, K_0_05, ONE);
              PC_F2: begin
                if (amb_hi) fat_q <= sat16({8'd0, fat_q} + r24, '0, ONE);
                else fat_q <= sat16({8'd0, fat_q} - r24, '0, ONE);
              end
              PC_A2: foc_q <= sat16({8'd0, foc_q} + r24, '0, ONE);
              default: begin
              end
            endcase
            if (pc_q == PC_L1) begin
              state_q <= (fat_over && fat_q != ONE) ? S_DIV : S_FIN;
            end else begin
              pc_q    <= pc_q + 5'd1;
              state_q <= S_ISSUE;
            end
          end
        end
        S_DIV: begin
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) state_q <= S_FIN;
        end
        S_FIN: begin
          if (load_out) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      dt_q     <= in_i.tick_time;
      amb_q    <= (in_i.ambient_level > ONE) ? ONE : in_i.ambient_level;
      rain_q   <= (in_i.rain_level > ONE) ? ONE : in_i.rain_level;
      bright_q <= in_i.bright_light;
    end
    if (state_q == S_WAIT && mul_done) begin
      case (pc_q)
        PC_BA: bamt_q  <= mul_r[14:0];
        PC_N1: night_q <= ONE + mul_r[15:0];
        PC_G2: glare_q <= sat16(r24, '0, ONE);
        PC_P1: t_q     <= 19'(mul_r) + u19(PERS_MIN);
        PC_R0: bt_q    <= K_0_3 + mul_r[15:0];
        PC_L1: begin
          lum_q  <= ONE + mul_r[15:0];
          cred_q <= fat_over ? K_0_3[14:0] : '0;
        end
        PC_D1, PC_B1, PC_G1, PC_P0, PC_P2, PC_R1, PC_R2, PC_F1, PC_A1: t_q <= 19'(mul_r);
        default: begin
        end
      endcase
    end
    if (state_q == S_DIVW && div_done) begin
      cred_q <= (div_quo > K_0_3[14:0]) ? K_0_3[14:0] : div_quo;
    end
    if (load_out) res_q <= res_d;
  end

  assign out_o.valid              = ovalid_q;
  assign out_o.dark_level         = res_q.dark_level;
  assign out_o.luma_gain          = res_q.luma_gain;
  assign out_o.contrast_scale     = res_q.contrast_scale;
  assign out_o.persistence_time   = res_q.persistence_time;
  assign out_o.bloom_level        = res_q.bloom_level;
  assign out_o.glare_level        = res_q.glare_level;
  assign out_o.display_brightness = res_q.display_brightness;
  assign out_o.brightness_gap     = res_q.brightness_gap;
  assign out_o.focus_level        = res_q.focus_level;
  assign out_o.raining            = res_q.raining;
  assign out_o.effect_active      = res_q.effect_active;
endmodule

[hdl/ava_checker.sv]
// Port-level checks of the visual adaptation block, bound to its top level.
module ava_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] luma_gain,
  input logic [15:0] contrast_scale,
  input logic [15:0] display_brightness
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(display_brightness))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_lum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> luma_gain >= 16'd32768 && luma_gain <= 16'd42599)
    else $error("luma gain out of range");

  a_bright_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> display_brightness >= 16'd1638 && display_brightness <= 16'd32768 &&
                  contrast_scale >= 16'd22937 && contrast_scale <= 16'd32768)
    else $error("brightness or contrast scale out of range");
endmodule

bind ambient_visual_adaptation ava_checker u_ava_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid           (in_i.valid),
  .in_ready           (in_i.ready),
  .out_valid          (out_o.valid),
  .out_ready          (out_o.ready),
  .luma_gain          (out_o.luma_gain),
  .contrast_scale     (out_o.contrast_scale),
  .display_brightness (out_o.display_brightness)
);
